@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the checker files.
// No dependencies; clocked on aclk, disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define WPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/wpm_pkg.sv @@
// Shared types and constants for the windowed point mean block.
// No dependencies.
package wpm_pkg;

    localparam logic [2:0] CFG_LIMIT_X   = 3'd0;
    localparam logic [2:0] CFG_LIMIT_Y   = 3'd1;
    localparam logic [2:0] CFG_LIMIT_Z   = 3'd2;
    localparam logic [2:0] CFG_MIN_COUNT = 3'd3;
    localparam logic [2:0] CFG_SHIFT_X   = 3'd4;
    localparam logic [2:0] CFG_DEFAULT   = 3'd5;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_WRITE,
        ENG_SUM,
        ENG_TEST,
        ENG_PREP,
        ENG_DIV,
        ENG_DONE
    } eng_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_RUN
    } top_state_t;

    typedef struct packed {
        logic [14:0] limit_x;
        logic [14:0] limit_y;
        logic [14:0] limit_z;
        logic [15:0] default_coord;
    } eng_cfg_t;

endpackage

@@ hw/rtl/wpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 6,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/wpm_engine.sv @@
// One point history: ring RAM, two read passes (mean, inlier test) and a
// bit-serial rounding divider. Depends on wpm_pkg and wpm_ram.
module wpm_engine import wpm_pkg::*; #(
    parameter int DEPTH = 6,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [AW-1:0] slot,
    input  logic [47:0]   wr_point,
    input  logic          wr_valid,
    input  eng_cfg_t      cfg,
    output logic          done,
    output logic [15:0]   mean_x,
    output logic [15:0]   mean_y,
    output logic [15:0]   mean_z,
    output logic [CW-1:0] total
);
    localparam int SW = 17 + CW;
    localparam int DW = SW + 1;
    localparam int LW = 15 + CW;
    localparam int NW = SW + 2;
    localparam int STW = $clog2(NW + 1);

    eng_state_t state_reg, state_next;
    logic [AW-1:0] slot_reg;
    logic [47:0] point_reg;
    logic pvalid_reg;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg;
    logic signed [SW-1:0] sum_reg [3], sum_next [3];
    logic signed [SW-1:0] isum_reg [3], isum_next [3];
    logic [CW-1:0] cnt_reg, cnt_next, icnt_reg, icnt_next;
    logic [NW-1:0] num_reg [3], num_next [3];
    logic [CW:0] rem_reg [3], rem_next [3];
    logic neg_reg [3], neg_next [3];
    logic [STW-1:0] step_reg, step_next;

    logic issue, ent_valid, ok;
    logic [47:0] rd_data;
    logic signed [15:0] p [3];
    logic signed [DW-1:0] prod, diff;
    logic [DW-1:0] dmag;
    logic [LW-1:0] lim;
    logic [14:0] lim_sel [3];
    logic [CW:0] den;
    logic [CW+1:0] trial;
    logic [SW-1:0] mag;
    logic [15:0] mean [3];

    wpm_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (state_reg == ENG_WRITE),
        .waddr (slot_reg),
        .wdata (point_reg),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    assign issue = (state_reg == ENG_SUM || state_reg == ENG_TEST)
                   && rd_idx_reg != CW'(DEPTH);
    assign ent_valid = pend_reg && valid_reg[pend_idx_reg];
    assign den = {icnt_reg, 1'b0};
    assign lim_sel[0] = cfg.limit_x;
    assign lim_sel[1] = cfg.limit_y;
    assign lim_sel[2] = cfg.limit_z;

    always_comb begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        rd_idx_next = issue ? rd_idx_reg + 1'b1 : rd_idx_reg;
        pend_next   = issue;
        cnt_next    = cnt_reg;
        icnt_next   = icnt_reg;
        step_next   = step_reg;
        ok          = 1'b1;
        prod        = '0;
        diff        = '0;
        dmag        = '0;
        lim         = '0;
        trial       = '0;
        mag         = '0;
        for (int a = 0; a < 3; a++) begin
            p[a]         = rd_data[16*a +: 16];
            sum_next[a]  = sum_reg[a];
            isum_next[a] = isum_reg[a];
            num_next[a]  = num_reg[a];
            rem_next[a]  = rem_reg[a];
            neg_next[a]  = neg_reg[a];
        end
        case (state_reg)
            ENG_IDLE, ENG_DONE: begin
                if (start) begin
                    state_next = ENG_WRITE;
                end
            end
            ENG_WRITE: begin
                valid_next[slot_reg] = pvalid_reg;
                rd_idx_next = '0;
                pend_next   = 1'b0;
                cnt_next    = '0;
                for (int a = 0; a < 3; a++) begin
                    sum_next[a] = '0;
                end
                state_next = ENG_SUM;
            end
            ENG_SUM: begin
                if (ent_valid) begin
                    cnt_next = cnt_reg + 1'b1;
                    for (int a = 0; a < 3; a++) begin
                        sum_next[a] = sum_reg[a] + SW'(p[a]);
                    end
                end
                if (!issue && !pend_reg) begin
                    rd_idx_next = '0;
                    icnt_next   = '0;
                    for (int a = 0; a < 3; a++) begin
                        isum_next[a] = '0;
                    end
                    state_next = ENG_TEST;
                end
            end
            ENG_TEST: begin
                // exact test: |p*n - sum| < limit*n on every axis
                for (int a = 0; a < 3; a++) begin
                    prod = DW'(p[a]) * DW'($signed({1'b0, cnt_reg}));
                    diff = prod - DW'(sum_reg[a]);
                    dmag = diff[DW-1] ? DW'(-diff) : DW'(diff);
                    lim  = LW'(lim_sel[a]) * LW'(cnt_reg);
                    if (!(dmag < DW'(lim))) begin
                        ok = 1'b0;
                    end
                end
                if (ent_valid && ok) begin
                    icnt_next = icnt_reg + 1'b1;
                    for (int a = 0; a < 3; a++) begin
                        isum_next[a] = isum_reg[a] + SW'(p[a]);
                    end
                end
                if (!issue && !pend_reg) begin
                    state_next = ENG_PREP;
                end
            end
            ENG_PREP: begin
                // round half away from zero: q = (2|s| + n) / 2n
                for (int a = 0; a < 3; a++) begin
                    neg_next[a] = isum_reg[a][SW-1];
                    mag = isum_reg[a][SW-1] ? SW'(-isum_reg[a]) : SW'(isum_reg[a]);
                    num_next[a] = (NW'(mag) << 1) + NW'(icnt_reg);
                    rem_next[a] = '0;
                end
                step_next  = '0;
                state_next = ENG_DIV;
            end
            ENG_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    trial = {rem_reg[a], num_reg[a][NW-1]};
                    if (trial >= {1'b0, den}) begin
                        rem_next[a] = CW'(1) == 0 ? '0 : (CW+1)'(trial - {1'b0, den});
                        num_next[a] = {num_reg[a][NW-2:0], 1'b1};
                    end else begin
                        rem_next[a] = trial[CW:0];
                        num_next[a] = {num_reg[a][NW-2:0], 1'b0};
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STW'(NW - 1)) begin
                    state_next = ENG_DONE;
                end
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_IDLE;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ENG_IDLE || state_reg == ENG_DONE) && start) begin
            slot_reg   <= slot;
            point_reg  <= wr_point;
            pvalid_reg <= wr_valid;
        end
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= rd_idx_reg[AW-1:0];
        cnt_reg      <= cnt_next;
        icnt_reg     <= icnt_next;
        step_reg     <= step_next;
        for (int a = 0; a < 3; a++) begin
            sum_reg[a]  <= sum_next[a];
            isum_reg[a] <= isum_next[a];
            num_reg[a]  <= num_next[a];
            rem_reg[a]  <= rem_next[a];
            neg_reg[a]  <= neg_next[a];
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (icnt_reg == '0) begin
                mean[a] = cfg.default_coord;
            end else begin
                mean[a] = neg_reg[a] ? 16'(-num_reg[a][15:0]) : num_reg[a][15:0];
            end
        end
    end

    assign done   = (state_reg == ENG_DONE);
    assign mean_x = mean[0];
    assign mean_y = mean[1];
    assign mean_z = mean[2];
    assign total  = icnt_reg;
endmodule

@@ hw/rtl/windowed_point_mean_outlier_reject_unit.sv @@
// Top level: configuration registers, write slot, two history engines, output register.
// Depends on wpm_pkg and wpm_engine.
//
// Usage:
//   s_* channel: one face point (with face_valid) and one eye point per transfer.
//   m_* channel: one result per input: inlier means of both histories (face x
//   plus output_shift_x), inlier totals and the focused flag.
//   cfg_* channel: register index and data, always ready; write only while idle.
// Timing: one item at a time. Each engine writes its entry, makes one RAM read
//   pass for the mean and one for the inlier test, then runs a
//   one-bit-per-cycle divider of 19+clog2(DEPTH+1) steps. s_ready returns when
//   the result is loaded into the output register.
// Reset: aresetn (synchronous, low) clears the valid marks, write slot, wrap
//   flag and registers to their defaults; no clearing pass is needed.
// Stall: a result waits in the output register while m_ready is low; the
//   next item may be accepted and run meanwhile, and finishes only once the
//   output register frees.
module windowed_point_mean_outlier_reject_unit import wpm_pkg::*; #(
    parameter int HISTORY_DEPTH = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_face_x,
    input  logic signed [15:0] s_face_y,
    input  logic signed [15:0] s_face_z,
    input  logic               s_face_valid,
    input  logic signed [15:0] s_eye_x,
    input  logic signed [15:0] s_eye_y,
    input  logic signed [15:0] s_eye_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_face_mean_x,
    output logic signed [15:0] m_face_mean_y,
    output logic signed [15:0] m_face_mean_z,
    output logic signed [15:0] m_eye_mean_x,
    output logic signed [15:0] m_eye_mean_y,
    output logic signed [15:0] m_eye_mean_z,
    output logic [6:0]         m_face_inlier_total,
    output logic [6:0]         m_eye_inlier_total,
    output logic               m_focused,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);

    top_state_t state_reg, state_next;
    logic [CW-1:0] slot_reg, slot_cur;
    logic wrapped_reg;
    logic [14:0] lim_x_reg, lim_y_reg, lim_z_reg;
    logic [6:0] min_cnt_reg;
    logic [15:0] shift_reg, default_reg;
    logic m_valid_reg;
    logic [16:0] fmx_reg;
    logic [15:0] fmy_reg, fmz_reg, emx_reg, emy_reg, emz_reg;
    logic [6:0] ft_reg, et_reg;
    logic focused_reg;

    eng_cfg_t eng_cfg;
    logic s_xfer, start, load, wrap;
    logic f_done, e_done;
    logic [15:0] f_mx, f_my, f_mz, e_mx, e_my, e_mz;
    logic [CW-1:0] f_tot, e_tot;

    assign s_ready   = (state_reg == TOP_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_valid && s_ready;
    assign start     = s_xfer;
    assign wrap      = (slot_reg == CW'(HISTORY_DEPTH));
    assign slot_cur  = wrap ? '0 : slot_reg;
    assign load      = (state_reg == TOP_RUN) && f_done && e_done
                       && (!m_valid_reg || m_ready);

    assign eng_cfg = '{limit_x: lim_x_reg, limit_y: lim_y_reg, limit_z: lim_z_reg,
                       default_coord: default_reg};

    wpm_engine #(.DEPTH(HISTORY_DEPTH)) u_face (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .slot     (slot_cur[AW-1:0]),
        .wr_point ({s_face_z, s_face_y, s_face_x}),
        .wr_valid (s_face_valid),
        .cfg      (eng_cfg),
        .done     (f_done),
        .mean_x   (f_mx),
        .mean_y   (f_my),
        .mean_z   (f_mz),
        .total    (f_tot)
    );

    wpm_engine #(.DEPTH(HISTORY_DEPTH)) u_eye (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .slot     (slot_cur[AW-1:0]),
        .wr_point ({s_eye_z, s_eye_y, s_eye_x}),
        .wr_valid (1'b1),
        .cfg      (eng_cfg),
        .done     (e_done),
        .mean_x   (e_mx),
        .mean_y   (e_my),
        .mean_z   (e_mz),
        .total    (e_tot)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE: if (s_xfer) state_next = TOP_RUN;
            TOP_RUN:  if (load) state_next = TOP_IDLE;
            default:  state_next = TOP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TOP_IDLE;
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            lim_x_reg   <= 15'd300;
            lim_y_reg   <= 15'd100;
            lim_z_reg   <= 15'd20;
            min_cnt_reg <= 7'd2;
            shift_reg   <= 16'd100;
            default_reg <= 16'd0;
        end else begin
            state_reg <= state_next;
            if (s_xfer) begin
                slot_reg <= slot_cur + 1'b1;
                if (wrap) begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LIMIT_X:   lim_x_reg   <= cfg_data[14:0];
                    CFG_LIMIT_Y:   lim_y_reg   <= cfg_data[14:0];
                    CFG_LIMIT_Z:   lim_z_reg   <= cfg_data[14:0];
                    CFG_MIN_COUNT: min_cnt_reg <= cfg_data[6:0];
                    CFG_SHIFT_X:   shift_reg   <= cfg_data;
                    CFG_DEFAULT:   default_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            fmx_reg     <= {f_mx[15], f_mx} + {shift_reg[15], shift_reg};
            fmy_reg     <= f_my;
            fmz_reg     <= f_mz;
            emx_reg     <= e_mx;
            emy_reg     <= e_my;
            emz_reg     <= e_mz;
            ft_reg      <= 7'(f_tot);
            et_reg      <= 7'(e_tot);
            focused_reg <= (7'(f_tot) > min_cnt_reg) && wrapped_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_face_mean_x       = fmx_reg;
    assign m_face_mean_y       = fmy_reg;
    assign m_face_mean_z       = fmz_reg;
    assign m_eye_mean_x        = emx_reg;
    assign m_eye_mean_y        = emy_reg;
    assign m_eye_mean_z        = emz_reg;
    assign m_face_inlier_total = ft_reg;
    assign m_eye_inlier_total  = et_reg;
    assign m_focused           = focused_reg;
endmodule

@@ hw/rtl/wpm_checker.sv @@
// Port-level checks for the windowed point mean top level, bound into it.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module wpm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [16:0] m_face_mean_x,
    input logic [6:0]  m_face_inlier_total,
    input logic        m_focused
);
    `WPM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_face_mean_x))
    `WPM_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)
    `WPM_ASSERT_NOW(a_focus_needs_inliers, m_valid && m_focused, m_face_inlier_total != 7'd0)
endmodule

bind windowed_point_mean_outlier_reject_unit wpm_checker u_wpm_checker (.*);

@@ tb/tb.sv @@
// Self-checking bench for windowed_point_mean_outlier_reject_unit.
// Directed table then random traffic, scored against a local history-mean predictor.
// Depends on wpm_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb;
    import wpm_pkg::*;

    localparam int DEPTH = 6;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_face_x = '0, s_face_y = '0, s_face_z = '0;
    logic               s_face_valid = 1'b0;
    logic signed [15:0] s_eye_x = '0, s_eye_y = '0, s_eye_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [16:0] m_face_mean_x;
    logic signed [15:0] m_face_mean_y, m_face_mean_z;
    logic signed [15:0] m_eye_mean_x, m_eye_mean_y, m_eye_mean_z;
    logic [6:0]         m_face_inlier_total, m_eye_inlier_total;
    logic               m_focused;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    windowed_point_mean_outlier_reject_unit #(.HISTORY_DEPTH(DEPTH)) uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    typedef struct {
        logic signed [15:0] fx, fy, fz;
        logic               fv;
        logic signed [15:0] ex, ey, ez;
    } point_pair_t;

    typedef struct {
        logic signed [16:0] fmx;
        logic signed [15:0] fmy, fmz, emx, emy, emz;
        logic [6:0]         ft, et;
        logic               foc;
    } mean_result_t;

    // predictor state
    int     face_pt[DEPTH][3], eye_pt[DEPTH][3];
    bit     face_ok[DEPTH], eye_ok[DEPTH], face_in[DEPTH], eye_in[DEPTH];
    int     slot;
    bit     wrapped;
    int     lim_x, lim_y, lim_z, min_cnt, shift_x, dflt;

    mean_result_t means_due[$];
    int           errors = 0;
    int           cycles = 0;
    int           rx_count = 0;
    bit           stall_en = 1'b1;
    bit           long_hold = 1'b0;

    function automatic int rounded_mean(longint s, longint n);
        longint mag, q;
        mag = (s < 0) ? -s : s;
        q = (mag * 2 + n) / (n * 2);
        return (s < 0) ? -q : q;
    endfunction

    // one history pass: full mean, inlier marks, inlier mean
    function automatic int history_means(ref int pt[DEPTH][3], ref bit ok[DEPTH],
                                         ref bit inl[DEPTH], output int mean[3]);
        longint sum[3], d, n;
        int     lim[3], total;
        bit     good;
        lim = '{lim_x, lim_y, lim_z};
        sum = '{0, 0, 0};
        n = 0;
        total = 0;
        for (int i = 0; i < DEPTH; i++)
            if (ok[i]) begin
                n++;
                for (int a = 0; a < 3; a++) sum[a] += pt[i][a];
            end
        for (int i = 0; i < DEPTH; i++) begin
            if (!ok[i]) continue;
            good = 1'b1;
            for (int a = 0; a < 3; a++) begin
                d = longint'(pt[i][a]) * n - sum[a];
                if (d < 0) d = -d;
                if (!(d < longint'(lim[a]) * n)) good = 1'b0;
            end
            inl[i] = good;
            if (good) total++;
        end
        sum = '{0, 0, 0};
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (ok[i] && inl[i]) begin
                n++;
                for (int a = 0; a < 3; a++) sum[a] += pt[i][a];
            end
        for (int a = 0; a < 3; a++) mean[a] = (n != 0) ? rounded_mean(sum[a], n) : dflt;
        return total;
    endfunction

    function automatic mean_result_t predict_means(point_pair_t p);
        mean_result_t r;
        int fm[3], em[3], ft, et;
        if (slot >= DEPTH) begin
            slot = 0;
            wrapped = 1'b1;
        end
        face_pt[slot] = '{p.fx, p.fy, p.fz};
        face_ok[slot] = p.fv;
        eye_pt[slot] = '{p.ex, p.ey, p.ez};
        eye_ok[slot] = 1'b1;
        ft = history_means(face_pt, face_ok, face_in, fm);
        et = history_means(eye_pt, eye_ok, eye_in, em);
        slot++;
        r.fmx = 17'(fm[0] + shift_x);
        r.fmy = 16'(fm[1]);
        r.fmz = 16'(fm[2]);
        r.emx = 16'(em[0]);
        r.emy = 16'(em[1]);
        r.emz = 16'(em[2]);
        r.ft = 7'(ft);
        r.et = 7'(et);
        r.foc = (ft > min_cnt) && wrapped;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d want %0d", rx_count, what, got, want);
        errors++;
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin : result_drain
        int burst;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 16);
                m_ready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        mean_result_t w;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (means_due.size() == 0) begin
                $display("result with nothing pending");
                errors++;
            end else begin
                w = means_due.pop_front();
                if (m_face_mean_x !== w.fmx) report_mismatch("face_mean_x", m_face_mean_x, w.fmx);
                if (m_face_mean_y !== w.fmy) report_mismatch("face_mean_y", m_face_mean_y, w.fmy);
                if (m_face_mean_z !== w.fmz) report_mismatch("face_mean_z", m_face_mean_z, w.fmz);
                if (m_eye_mean_x !== w.emx) report_mismatch("eye_mean_x", m_eye_mean_x, w.emx);
                if (m_eye_mean_y !== w.emy) report_mismatch("eye_mean_y", m_eye_mean_y, w.emy);
                if (m_eye_mean_z !== w.emz) report_mismatch("eye_mean_z", m_eye_mean_z, w.emz);
                if (m_face_inlier_total !== w.ft)
                    report_mismatch("face_inlier_total", m_face_inlier_total, w.ft);
                if (m_eye_inlier_total !== w.et)
                    report_mismatch("eye_inlier_total", m_eye_inlier_total, w.et);
                if (m_focused !== w.foc) report_mismatch("focused", m_focused, w.foc);
            end
            rx_count++;
        end
    end

    always @(posedge aclk)
        if (cycles > 2_000_000) begin
            $display("tb: done, errors");
            $finish;
        end

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LIMIT_X:   lim_x = val & 16'h7fff;
            CFG_LIMIT_Y:   lim_y = val & 16'h7fff;
            CFG_LIMIT_Z:   lim_z = val & 16'h7fff;
            CFG_MIN_COUNT: min_cnt = val & 7'h7f;
            CFG_SHIFT_X:   shift_x = int'($signed(16'(val)));
            CFG_DEFAULT:   dflt = int'($signed(16'(val)));
            default: ;
        endcase
    endtask

    task automatic write_all(int lx, int ly, int lz, int mc, int sx, int dc);
        write_reg(CFG_LIMIT_X, lx);
        write_reg(CFG_LIMIT_Y, ly);
        write_reg(CFG_LIMIT_Z, lz);
        write_reg(CFG_MIN_COUNT, mc);
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_DEFAULT, dc);
    endtask

    // wait for every pending result plus the pipeline tail
    task automatic drain_pipe();
        while (means_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send_pair(point_pair_t p, bit gaps);
        int burst;
        if (gaps && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (burst) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_face_x <= p.fx;
        s_face_y <= p.fy;
        s_face_z <= p.fz;
        s_face_valid <= p.fv;
        s_eye_x <= p.ex;
        s_eye_y <= p.ey;
        s_eye_z <= p.ez;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        means_due.push_back(predict_means(p));
    endtask

    function automatic logic signed [15:0] near_pt(int centre, int spread);
        return 16'(centre + $urandom_range(0, 2 * spread) - spread);
    endfunction

    function automatic point_pair_t random_pair(int mode);
        point_pair_t p;
        if (mode == 0) begin
            p.fx = 16'($urandom);
            p.fy = 16'($urandom);
            p.fz = 16'($urandom);
            p.ex = 16'($urandom);
            p.ey = 16'($urandom);
            p.ez = 16'($urandom);
        end else begin
            // clustered points with occasional outliers, so inlier tests go both ways
            p.fx = near_pt(500, ($urandom_range(0, 7) == 0) ? 3000 : 200);
            p.fy = near_pt(-300, ($urandom_range(0, 7) == 0) ? 1000 : 60);
            p.fz = near_pt(1000, ($urandom_range(0, 7) == 0) ? 200 : 15);
            p.ex = near_pt(-800, ($urandom_range(0, 7) == 0) ? 3000 : 200);
            p.ey = near_pt(200, ($urandom_range(0, 7) == 0) ? 1000 : 60);
            p.ez = near_pt(900, ($urandom_range(0, 7) == 0) ? 200 : 15);
        end
        p.fv = ($urandom_range(0, 4) != 0);
        return p;
    endfunction

    typedef struct {
        point_pair_t  p;
        bit           known;
        mean_result_t r;
    } table_row_t;

    initial begin : stimulus
        table_row_t   rows[$];
        table_row_t   t;
        mean_result_t pr;
        int           n_rand;

        face_ok = '{default: 0};
        eye_ok = '{default: 0};
        face_in = '{default: 0};
        eye_in = '{default: 0};
        slot = 0;
        wrapped = 1'b0;
        lim_x = 300; lim_y = 100; lim_z = 20; min_cnt = 2; shift_x = 100; dflt = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first item after reset, face invalid: face mean is the default plus shift
        t.p = '{16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd10, -16'sd20, 16'sd30};
        t.known = 1'b1;
        t.r = '{17'sd100, 16'sd0, 16'sd0, 16'sd10, -16'sd20, 16'sd30, 7'd0, 7'd1, 1'b0};
        rows.push_back(t);
        // one valid face entry: it is its own mean
        t.p = '{16'sd32767, -16'sd32768, 16'sd5, 1'b1, 16'sd10, -16'sd20, 16'sd30};
        t.r = '{17'sd32867, -16'sd32768, 16'sd5, 16'sd10, -16'sd20, 16'sd30, 7'd1, 7'd2, 1'b0};
        rows.push_back(t);
        t.known = 1'b0;
        t.p = '{-16'sd32768, 16'sd32767, -16'sd1, 1'b1, 16'sd32767, 16'sd32767, 16'sd32767};
        rows.push_back(t);
        t.p = '{16'sd1, 16'sd1, 16'sd1, 1'b1, -16'sd32768, -16'sd32768, -16'sd32768};
        rows.push_back(t);
        for (int i = 0; i < 10; i++) begin
            // identical points: all inliers; wrap turns focused on
            t.p = '{16'sd7, 16'sd7, 16'sd7, 1'b1, -16'sd3, -16'sd3, -16'sd3};
            rows.push_back(t);
        end
        t.p = '{16'sd8, 16'sd7, 16'sd7, 1'b1, -16'sd3, -16'sd3, -16'sd2};
        rows.push_back(t);
        t.p = '{-16'sd1, -16'sd1, -16'sd1, 1'b0, -16'sd1, -16'sd1, -16'sd1};
        rows.push_back(t);

        foreach (rows[i]) begin
            send_pair(rows[i].p, 1'b0);
            pr = means_due[$];
            if (rows[i].known && pr != rows[i].r) begin
                $display("directed row %0d disagrees with predictor", i);
                errors++;
            end
        end
        s_valid <= 1'b0;
        drain_pipe();

        // extremes: zero limits (nothing is an inlier), min count 64, negative shift
        write_all(0, 0, 0, 64, -32768, -32768);
        for (int i = 0; i < 40; i++) send_pair(random_pair(i % 2), 1'b1);
        s_valid <= 1'b0;
        drain_pipe();

        write_all(32767, 32767, 32767, 0, 32767, 32767);
        for (int i = 0; i < 40; i++) send_pair(random_pair(i % 2), 1'b1);
        s_valid <= 1'b0;
        drain_pipe();

        // long receiver hold while the sender keeps offering
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++) send_pair(random_pair(1), 1'b0);
        s_valid <= 1'b0;
        drain_pipe();

        for (int ph = 0; ph < 6; ph++) begin
            write_all($urandom_range(0, 32767) % (ph < 3 ? 1000 : 32768),
                      $urandom_range(0, 400), $urandom_range(0, 100),
                      $urandom_range(0, 6), $urandom, $urandom);
            n_rand = 300;
            if (ph == 5) stall_en = 1'b0;
            for (int i = 0; i < n_rand; i++)
                send_pair(random_pair($urandom_range(0, 3) != 0), ph != 5);
            s_valid <= 1'b0;
            drain_pipe();
        end

        if (errors == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end
endmodule
